// ===== rtl/u8s_pkg.sv =====
// Shared types and byte constants for the UTF-8 sanitizer.
`default_nettype none
package u8s_pkg;

	localparam int unsigned MaxEmit   = 6;
	localparam int unsigned HeldDepth = 3;

	// Replacement character U+FFFD in UTF-8
	localparam logic [7:0] ReplByte0 = 8'hEF;
	localparam logic [7:0] ReplByte1 = 8'hBF;
	localparam logic [7:0] ReplByte2 = 8'hBD;

	// Lead classes
	localparam logic [7:0] AsciiLimit = 8'h80;
	localparam logic [7:0] Lead2Lo    = 8'hC2;
	localparam logic [7:0] Lead2Hi    = 8'hDF;
	localparam logic [7:0] Lead3Lo    = 8'hE0;
	localparam logic [7:0] Lead3Hi    = 8'hEF;
	localparam logic [7:0] Lead4Lo    = 8'hF0;
	localparam logic [7:0] Lead4Hi    = 8'hF4;
	localparam logic [7:0] LeadEd     = 8'hED;

	// Continuation ranges
	localparam logic [7:0] ContLo     = 8'h80;
	localparam logic [7:0] ContHi     = 8'hBF;
	localparam logic [7:0] AfterE0Lo  = 8'hA0;
	localparam logic [7:0] AfterEdHi  = 8'h9F;
	localparam logic [7:0] AfterF0Lo  = 8'h90;
	localparam logic [7:0] AfterF4Hi  = 8'h8F;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} u8s_in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
	} u8s_out_t;

	// Pending-sequence state
	typedef struct packed {
		logic [HeldDepth-1:0][7:0] held;
		logic [1:0]                held_cnt;
		logic [1:0]                need_cnt;
	} u8s_state_t;

	// Bytes produced by one request
	typedef struct packed {
		logic [MaxEmit-1:0][7:0] bytes;
		logic [2:0]              cnt;
		logic                    last;
	} u8s_burst_t;

endpackage
`default_nettype wire

// ===== rtl/u8s_step.sv =====
// Per-byte decode step: next pending state and the burst of output bytes.
`default_nettype none
module u8s_step (
	input  wire u8s_pkg::u8s_state_t cur,
	input  wire u8s_pkg::u8s_in_t    item,
	output u8s_pkg::u8s_state_t      nxt,
	output u8s_pkg::u8s_burst_t      burst
);

	logic [7:0] b;
	logic       pending;
	logic       first_cont;
	logic [7:0] lo;
	logic [7:0] hi;
	logic       in_range;

	assign b          = item.in_byte;
	assign pending    = (cur.held_cnt != 2'd0) && (cur.need_cnt != 2'd0);
	assign first_cont = (cur.held_cnt == 2'd1);

	always_comb begin
		lo = u8s_pkg::ContLo;
		hi = u8s_pkg::ContHi;
		if (first_cont && cur.held[0] == u8s_pkg::Lead3Lo) begin
			lo = u8s_pkg::AfterE0Lo;
		end
		if (first_cont && cur.held[0] == u8s_pkg::Lead4Lo) begin
			lo = u8s_pkg::AfterF0Lo;
		end
		if (first_cont && cur.held[0] == u8s_pkg::LeadEd) begin
			hi = u8s_pkg::AfterEdHi;
		end
		if (first_cont && cur.held[0] == u8s_pkg::Lead4Hi) begin
			hi = u8s_pkg::AfterF4Hi;
		end
	end

	assign in_range = (b >= lo) && (b <= hi);

	always_comb begin
		logic [2:0] n;
		logic       as_lead;
		n     = 3'd0;
		nxt   = cur;
		burst = '0;
		as_lead = !pending;

		if (pending) begin
			if (!in_range) begin
				// Broken sequence: replace, drop held bytes, retry byte as a lead
				burst.bytes[0] = u8s_pkg::ReplByte0;
				burst.bytes[1] = u8s_pkg::ReplByte1;
				burst.bytes[2] = u8s_pkg::ReplByte2;
				n = 3'd3;
				nxt.held_cnt = 2'd0;
				nxt.need_cnt = 2'd0;
				as_lead = 1'b1;
			end else if (cur.need_cnt <= 2'd1) begin
				// Sequence complete: release held bytes then this one
				for (int i = 0; i < u8s_pkg::HeldDepth; i++) begin
					if (i < int'(cur.held_cnt)) begin
						burst.bytes[n] = cur.held[i];
						n = n + 3'd1;
					end
				end
				burst.bytes[n] = b;
				n = n + 3'd1;
				nxt.held_cnt = 2'd0;
				nxt.need_cnt = 2'd0;
			end else begin
				nxt.held[cur.held_cnt] = b;
				nxt.held_cnt = cur.held_cnt + 2'd1;
				nxt.need_cnt = cur.need_cnt - 2'd1;
			end
		end else begin
			nxt.held_cnt = 2'd0;
			nxt.need_cnt = 2'd0;
		end

		if (as_lead) begin
			if (b < u8s_pkg::AsciiLimit) begin
				burst.bytes[n] = b;
				n = n + 3'd1;
			end else if (b >= u8s_pkg::Lead2Lo && b <= u8s_pkg::Lead2Hi) begin
				nxt.held[0]  = b;
				nxt.held_cnt = 2'd1;
				nxt.need_cnt = 2'd1;
			end else if (b >= u8s_pkg::Lead3Lo && b <= u8s_pkg::Lead3Hi) begin
				nxt.held[0]  = b;
				nxt.held_cnt = 2'd1;
				nxt.need_cnt = 2'd2;
			end else if (b >= u8s_pkg::Lead4Lo && b <= u8s_pkg::Lead4Hi) begin
				nxt.held[0]  = b;
				nxt.held_cnt = 2'd1;
				nxt.need_cnt = 2'd3;
			end else begin
				burst.bytes[n] = u8s_pkg::ReplByte0;
				n = n + 3'd1;
				burst.bytes[n] = u8s_pkg::ReplByte1;
				n = n + 3'd1;
				burst.bytes[n] = u8s_pkg::ReplByte2;
				n = n + 3'd1;
			end
		end

		// Replace whatever is still pending at end of buffer with U+FFFD
		if (item.in_last && nxt.held_cnt != 2'd0) begin
			burst.bytes[n] = u8s_pkg::ReplByte0;
			n = n + 3'd1;
			burst.bytes[n] = u8s_pkg::ReplByte1;
			n = n + 3'd1;
			burst.bytes[n] = u8s_pkg::ReplByte2;
			n = n + 3'd1;
			nxt.held_cnt = 2'd0;
			nxt.need_cnt = 2'd0;
		end

		burst.cnt  = n;
		burst.last = item.in_last;
	end

endmodule
`default_nettype wire

// ===== rtl/utf8_sanitize_replace_core.sv =====
// Top level of the streaming UTF-8 sanitizer with U+FFFD replacement.
//
//   channel | handshake          | payload             | role
//   --------+--------------------+---------------------+----------------------------
//   raw     | raw_valid/ready    | u8s_in_t  (9 bits)  | raw byte requests in
//   clean   | clean_valid/ready  | u8s_out_t (9 bits)  | sanitized byte requests out
//
// Flow: a byte request is registered (s1) and decoded combinationally into a burst of
// 0 to 6 bytes held in s2, which leaves one byte per cycle while clean is ready. A
// request that yields no bytes retires from s1 without waiting for s2, so ASCII and
// valid multi-byte text sustain one request per cycle while clean is ready; s2 holds a
// replacement until its three bytes leave, a broken sequence and invalid lead until six.
// Reset clears the pending-sequence state and both valid flags; burst data are not
// reset. Stalls on clean hold s2, then hold s1 behind it and deassert raw_ready.
`default_nettype none
module utf8_sanitize_replace_core (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                raw_valid,
	output logic               raw_ready,
	input  wire u8s_pkg::u8s_in_t raw,
	output logic               clean_valid,
	input  wire                clean_ready,
	output u8s_pkg::u8s_out_t  clean
);

	// Input register stage
	logic              valid_s1;
	u8s_pkg::u8s_in_t  item_s1;

	// Pending-sequence state
	u8s_pkg::u8s_state_t st_q;
	u8s_pkg::u8s_state_t st_d;

	// Burst register stage
	u8s_pkg::u8s_burst_t burst_d;
	logic                valid_s2;
	logic [u8s_pkg::MaxEmit-1:0][7:0] bytes_s2;
	logic [2:0]          cnt_s2;
	logic                last_s2;
	logic [2:0]          idx_q;

	logic [2:0] final_idx;
	logic       final_beat;
	logic       s2_free;
	logic       load_s2;
	logic       adv_s1;
	logic       take;

	u8s_step u_step (
		.cur   (st_q),
		.item  (item_s1),
		.nxt   (st_d),
		.burst (burst_d)
	);

	assign final_idx  = cnt_s2 - 3'd1;
	assign take       = clean_valid && clean_ready;
	assign final_beat = take && (idx_q == final_idx);
	// s2 can take a new burst when empty or when its final byte leaves now
	assign s2_free    = !valid_s2 || final_beat;
	assign load_s2    = valid_s1 && s2_free;
	// A request with no output bytes never needs s2
	assign adv_s1     = load_s2 || (valid_s1 && (burst_d.cnt == 3'd0));
	assign raw_ready  = !valid_s1 || adv_s1;

	assign clean_valid    = valid_s2;
	assign clean.out_byte = bytes_s2[idx_q];
	assign clean.out_last = last_s2 && (idx_q == final_idx);

	// Hold the request until the decoder can consume it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (raw_ready) begin
			valid_s1 <= raw_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (raw_valid && raw_ready) begin
			item_s1 <= raw;
		end
	end

	// Advance the pending state with each decoded request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (adv_s1) begin
			st_q <= st_d;
		end
	end

	// Load a burst, or step through the current one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_q    <= 3'd0;
		end else if (load_s2) begin
			valid_s2 <= (burst_d.cnt != 3'd0);
			idx_q    <= 3'd0;
		end else if (final_beat) begin
			valid_s2 <= 1'b0;
			idx_q    <= 3'd0;
		end else if (take) begin
			idx_q    <= idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			bytes_s2 <= burst_d.bytes;
			cnt_s2   <= burst_d.cnt;
			last_s2  <= burst_d.last;
		end
	end

	// A burst in flight is never empty and never longer than six bytes
	a_burst_len: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (cnt_s2 != 3'd0) && (cnt_s2 <= 3'd6))
		else $error("burst length out of range");

	// The read pointer stays inside the burst
	a_idx_in_burst: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (idx_q < cnt_s2))
		else $error("burst read pointer past end");

	// Held bytes and missing continuations are zero together
	a_pending_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.held_cnt == 2'd0) == (st_q.need_cnt == 2'd0))
		else $error("pending counters disagree");

	// A waiting output byte stays put until taken
	a_clean_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(clean_valid && !clean_ready) |=> (clean_valid && $stable(clean)))
		else $error("output byte changed while waiting");

endmodule
`default_nettype wire
